// ===== hw/rtl/deu_pkg.sv =====
// ----------------------------------------------------------------------------
// deu_pkg
// Shared widths, codes and record type for the digitizer event unpacker.
// ----------------------------------------------------------------------------
package deu_pkg;

    localparam int WORD_W       = 32;
    localparam int KIND_W       = 3;
    localparam int GROUP_W      = 2;
    localparam int SAMPLE_W     = 12;
    localparam int NUM_VALS     = 8;
    localparam int NUM_GROUPS_DEF = 4;
    localparam int MAX_GROUPS   = 4;

    typedef enum logic [2:0] {
        PH_EVHDR,
        PH_GRHDR,
        PH_SAMP,
        PH_TRIG,
        PH_TTAG
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVHDR = 3'd0,
        KIND_GRHDR = 3'd1,
        KIND_SAMP  = 3'd2,
        KIND_TRIG  = 3'd3,
        KIND_TTAG  = 3'd4
    } t_kind;

    typedef logic [NUM_VALS-1:0][SAMPLE_W-1:0] t_vals;

    typedef struct packed {
        t_kind                rec_kind;
        logic [GROUP_W-1:0]   group_num;
        logic [WORD_W-1:0]    aux;
        t_vals                vals;
        logic                 event_last;
    } t_rec;

endpackage

// ===== hw/rtl/deu_stream_ifs.sv =====
// ----------------------------------------------------------------------------
// deu stream interfaces
// Valid/ready channels for readout words and unpacked records.
// ----------------------------------------------------------------------------
interface deu_word_if import deu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);
endinterface

interface deu_rec_if import deu_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   rec_kind;
    logic [GROUP_W-1:0]  group_num;
    logic [WORD_W-1:0]   aux;
    logic [SAMPLE_W-1:0] val0;
    logic [SAMPLE_W-1:0] val1;
    logic [SAMPLE_W-1:0] val2;
    logic [SAMPLE_W-1:0] val3;
    logic [SAMPLE_W-1:0] val4;
    logic [SAMPLE_W-1:0] val5;
    logic [SAMPLE_W-1:0] val6;
    logic [SAMPLE_W-1:0] val7;
    logic                event_last;

    modport source (
        output valid, output rec_kind, output group_num, output aux,
        output val0, output val1, output val2, output val3,
        output val4, output val5, output val6, output val7,
        output event_last, input ready
    );
    modport sink (
        input valid, input rec_kind, input group_num, input aux,
        input val0, input val1, input val2, input val3,
        input val4, input val5, input val6, input val7,
        input event_last, output ready
    );
endinterface

// ===== hw/rtl/digitizer_event_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// digitizer_event_unpacker_core
// Parses a digitizer readout word stream into event, group, sample, trigger
// and time tag records.
// ----------------------------------------------------------------------------
// One readout word is taken per clock while the output can accept it. Each
// word is decoded in a single pass against the parser state, and any record
// it completes is in the output register in the cycle after the transfer.
// The output register is the only buffering: a new word is taken whenever
// the register is empty or its record is taken in the same cycle, so the
// sustained rate is one word per cycle with no reset sweep.
module digitizer_event_unpacker_core import deu_pkg::*; #(
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deu_word_if.sink   i_word,
    deu_rec_if.source  o_rec
);

    localparam logic [MAX_GROUPS-1:0] GROUP_MASK = MAX_GROUPS'((1 << NUM_GROUPS) - 1);
    localparam logic [16:0]           RECIP3     = 17'd43691;

    typedef struct packed {
        logic               found;
        logic [GROUP_W-1:0] idx;
    } t_find;

    function automatic t_find find_group(input logic [MAX_GROUPS-1:0] mask,
                                         input logic [2:0] start);
        t_find res;
        res = '0;
        for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
            if (mask[g] && (3'(g) >= start)) begin
                res.found = 1'b1;
                res.idx   = GROUP_W'(g);
            end
        end
        return res;
    endfunction

    function automatic logic [10:0] div3(input logic [11:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(RECIP3);
        return p[27:17];
    endfunction

    function automatic t_vals unpack_triple(input logic [WORD_W-1:0] w0,
                                            input logic [WORD_W-1:0] w1,
                                            input logic [WORD_W-1:0] w2);
        t_vals v;
        v[0] = w0[11:0];
        v[1] = w0[23:12];
        v[2] = {w1[3:0], w0[31:24]};
        v[3] = w1[15:4];
        v[4] = w1[27:16];
        v[5] = {w2[7:0], w1[31:28]};
        v[6] = w2[19:8];
        v[7] = w2[31:20];
        return v;
    endfunction

    t_phase                 r_phase,     n_phase;
    logic [1:0]             r_hdr_cnt,   n_hdr_cnt;
    logic [27:0]            r_ev_size,   n_ev_size;
    logic [MAX_GROUPS-1:0]  r_groups,    n_groups;
    logic [GROUP_W-1:0]     r_group,     n_group;
    logic [10:0]            r_spc,       n_spc;
    logic                   r_trig,      n_trig;
    logic [11:0]            r_words_rem, n_words_rem;
    logic [1:0]             r_tpos,      n_tpos;
    logic [1:0][WORD_W-1:0] r_held,      n_held;
    logic [10:0]            r_tidx,      n_tidx;
    t_rec                   r_out,       n_out;
    logic                   r_out_valid;

    logic              in_accept;
    logic              emit;
    logic [WORD_W-1:0] w;
    logic [10:0]       hdr_spc;
    logic [11:0]       three_spc;
    logic [11:0]       words_dec;
    logic [8:0]        trig_words;
    t_find             fnd;

    assign i_word.ready = !r_out_valid || o_rec.ready;
    assign in_accept    = i_word.valid && i_word.ready;
    assign w            = i_word.word_in;
    assign hdr_spc      = div3(w[11:0]);
    assign three_spc    = {r_spc, 1'b0} + {1'b0, r_spc};
    assign trig_words   = three_spc[11:3];
    assign words_dec    = (r_words_rem != '0) ? r_words_rem - 12'd1 : r_words_rem;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_ev_size   = r_ev_size;
        n_groups    = r_groups;
        n_group     = r_group;
        n_spc       = r_spc;
        n_trig      = r_trig;
        n_words_rem = r_words_rem;
        n_tpos      = r_tpos;
        n_held      = r_held;
        n_tidx      = r_tidx;
        n_out       = '0;
        emit        = 1'b0;
        fnd         = '0;

        unique case (r_phase)
            PH_EVHDR: begin
                if (r_hdr_cnt == 2'd0) begin
                    n_ev_size = w[27:0];
                end
                if (r_hdr_cnt == 2'd1) begin
                    n_groups = w[MAX_GROUPS-1:0];
                end
                if (r_hdr_cnt != 2'd3) begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                end else begin
                    emit             = 1'b1;
                    n_out.rec_kind   = KIND_EVHDR;
                    n_out.aux        = {4'b0, r_ev_size};
                    n_out.vals[0]    = {8'b0, r_groups};
                    n_groups         = r_groups & GROUP_MASK;
                    n_hdr_cnt        = 2'd0;
                    fnd              = find_group(r_groups & GROUP_MASK, 3'd0);
                    if (!fnd.found) begin
                        n_out.event_last = 1'b1;
                    end else begin
                        n_group = fnd.idx;
                        n_phase = PH_GRHDR;
                    end
                end
            end
            PH_GRHDR: begin
                emit            = 1'b1;
                n_spc           = hdr_spc;
                n_trig          = w[12];
                n_out.rec_kind  = KIND_GRHDR;
                n_out.group_num = r_group;
                n_out.vals[0]   = {1'b0, hdr_spc};
                n_out.vals[1]   = {11'b0, w[12]};
                n_out.vals[2]   = {10'b0, w[17:16]};
                n_out.vals[3]   = {2'b0, w[29:20]};
                n_tpos          = 2'd0;
                n_tidx          = '0;
                if (hdr_spc != '0) begin
                    n_words_rem = {hdr_spc, 1'b0} + {1'b0, hdr_spc};
                    n_phase     = PH_SAMP;
                end else begin
                    n_phase = PH_TTAG;
                end
            end
            PH_SAMP, PH_TRIG: begin
                if (!r_tpos[1]) begin
                    n_held[r_tpos[0]] = w;
                    n_tpos            = r_tpos + 2'd1;
                end else begin
                    emit            = 1'b1;
                    n_out.rec_kind  = (r_phase == PH_SAMP) ? KIND_SAMP : KIND_TRIG;
                    n_out.group_num = r_group;
                    n_out.aux       = {21'b0, r_tidx};
                    n_out.vals      = unpack_triple(r_held[0], r_held[1], w);
                    n_tidx          = r_tidx + 11'd1;
                    n_tpos          = 2'd0;
                end
                n_words_rem = words_dec;
                if (words_dec == '0) begin
                    n_tpos = 2'd0;
                    n_tidx = '0;
                    if (r_phase == PH_SAMP && r_trig && trig_words != '0) begin
                        n_words_rem = {3'b0, trig_words};
                        n_phase     = PH_TRIG;
                    end else begin
                        n_phase = PH_TTAG;
                    end
                end
            end
            PH_TTAG: begin
                emit            = 1'b1;
                n_out.rec_kind  = KIND_TTAG;
                n_out.group_num = r_group;
                n_out.aux       = w;
                fnd             = find_group(r_groups, {1'b0, r_group} + 3'd1);
                if (!fnd.found) begin
                    n_out.event_last = 1'b1;
                    n_phase          = PH_EVHDR;
                    n_hdr_cnt        = 2'd0;
                end else begin
                    n_group = fnd.idx;
                    n_phase = PH_GRHDR;
                end
            end
            default: begin
                n_phase     = PH_EVHDR;
                n_hdr_cnt   = '0;
                n_ev_size   = '0;
                n_groups    = '0;
                n_group     = '0;
                n_spc       = '0;
                n_trig      = 1'b0;
                n_words_rem = '0;
                n_tpos      = '0;
                n_held      = '0;
                n_tidx      = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_EVHDR;
            r_hdr_cnt   <= '0;
            r_ev_size   <= '0;
            r_groups    <= '0;
            r_group     <= '0;
            r_spc       <= '0;
            r_trig      <= 1'b0;
            r_words_rem <= '0;
            r_tpos      <= '0;
            r_tidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_ev_size   <= n_ev_size;
                r_groups    <= n_groups;
                r_group     <= n_group;
                r_spc       <= n_spc;
                r_trig      <= n_trig;
                r_words_rem <= n_words_rem;
                r_tpos      <= n_tpos;
                r_tidx      <= n_tidx;
                r_out_valid <= emit;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_held <= n_held;
        end
        if (in_accept && emit) begin
            r_out <= n_out;
        end
    end

    assign o_rec.valid      = r_out_valid;
    assign o_rec.rec_kind   = r_out.rec_kind;
    assign o_rec.group_num  = r_out.group_num;
    assign o_rec.aux        = r_out.aux;
    assign o_rec.val0       = r_out.vals[0];
    assign o_rec.val1       = r_out.vals[1];
    assign o_rec.val2       = r_out.vals[2];
    assign o_rec.val3       = r_out.vals[3];
    assign o_rec.val4       = r_out.vals[4];
    assign o_rec.val5       = r_out.vals[5];
    assign o_rec.val6       = r_out.vals[6];
    assign o_rec.val7       = r_out.vals[7];
    assign o_rec.event_last = r_out.event_last;

`ifndef SYNTH
    a_tpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos != 2'd3)
        else $error("triple position out of range");

    a_section_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SAMP || r_phase == PH_TRIG) |-> r_words_rem != '0)
        else $error("sample section entered with no words left");

    a_partial_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_SAMP && r_tpos == 2'd0) |=> !o_rec.valid)
        else $error("record produced on first word of a triple");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && o_rec.event_last) |->
            (o_rec.rec_kind == KIND_EVHDR || o_rec.rec_kind == KIND_TTAG))
        else $error("event end on a record that cannot close an event");
`endif

endmodule
